@@ rtl/c6502_pkg.sv @@
// Package for the 6502 load/store core: constants, opcodes and shared types.
// Used by c6502_mem and cpu_6502_load_store_core in rtl/.
package c6502_pkg;

  localparam int PageBytes    = 4096;
  localparam int RomFirstPage = 12;
  localparam int RomBytes     = 16384;
  localparam int MemDepth     = 65536;
  localparam int AddrW        = 16;

  localparam logic [1:0] ModeLoad  = 2'd0;
  localparam logic [1:0] ModeReset = 2'd1;
  localparam logic [1:0] ModeRun   = 2'd2;

  localparam logic [15:0] VecLo = 16'hFFFC;
  localparam logic [15:0] VecHi = 16'hFFFD;

  localparam logic [7:0] OpLdaImm = 8'hA9, OpLdaZp = 8'hA5, OpLdaZpx = 8'hB5;
  localparam logic [7:0] OpLdaAbs = 8'hAD, OpLdaAbx = 8'hBD, OpLdaAby = 8'hB9;
  localparam logic [7:0] OpLdaIzx = 8'hA1, OpLdaIzy = 8'hB1;
  localparam logic [7:0] OpLdxImm = 8'hA2, OpLdxZp = 8'hA6, OpLdxZpy = 8'hB6;
  localparam logic [7:0] OpLdxAbs = 8'hAE, OpLdxAby = 8'hBE;
  localparam logic [7:0] OpLdyImm = 8'hA0, OpLdyZp = 8'hA4, OpLdyZpx = 8'hB4;
  localparam logic [7:0] OpLdyAbs = 8'hAC, OpLdyAbx = 8'hBC;
  localparam logic [7:0] OpStaZp = 8'h85, OpStaZpx = 8'h95, OpStaAbs = 8'h8D;
  localparam logic [7:0] OpStaAbx = 8'h9D, OpStaAby = 8'h99;
  localparam logic [7:0] OpStxZp = 8'h86, OpStxZpy = 8'h96, OpStxAbs = 8'h8E;
  localparam logic [7:0] OpStyZp = 8'h84, OpStyZpx = 8'h94, OpStyAbs = 8'h8C;
  localparam logic [7:0] OpTax = 8'hAA, OpTay = 8'hA8, OpTxa = 8'h8A;
  localparam logic [7:0] OpTya = 8'h98, OpTsx = 8'hBA, OpTxs = 8'h9A;
  localparam logic [7:0] OpPha = 8'h48, OpPhp = 8'h08, OpPla = 8'h68;
  localparam logic [7:0] OpPlp = 8'h28, OpJmp = 8'h4C;

  // Request from the sequencer to the memory wrapper.
  typedef struct packed {
    logic        wr;
    logic        rd;
    logic [15:0] addr;
    logic [7:0]  data;
  } mem_req_t;

endpackage

@@ rtl/c6502_ram.sv @@
// Generic single-port synchronous RAM with registered read.
// No dependencies.
module c6502_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

@@ rtl/c6502_mem.sv @@
// Byte memory of the core: RAM instance, ROM write filter and clearing pass.
// Depends on c6502_pkg and c6502_ram.
module c6502_mem #(
  parameter int PageBytes    = c6502_pkg::PageBytes,
  parameter int RomFirstPage = c6502_pkg::RomFirstPage,
  parameter int RomBytes     = c6502_pkg::RomBytes
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  c6502_pkg::mem_req_t req_i,
  input  logic                host_i,
  output logic [7:0]          rdata_o,
  output logic                clr_busy_o
);
  localparam int RomLo = RomFirstPage * PageBytes;
  localparam int RomHiRaw = RomLo + RomBytes;
  localparam int RomHi = (RomHiRaw > c6502_pkg::MemDepth) ? c6502_pkg::MemDepth : RomHiRaw;

  logic [16:0] clr_q, clr_d;
  logic        in_rom, we;
  logic [15:0] addr;
  logic [7:0]  wdata;

  assign clr_busy_o = !clr_q[16];
  assign in_rom = ({1'b0, req_i.addr} >= 17'(RomLo)) && ({1'b0, req_i.addr} < 17'(RomHi));

  always_comb begin
    clr_d = clr_q;
    if (clr_busy_o) begin
      we    = 1'b1;
      addr  = clr_q[15:0];
      wdata = 8'h00;
      clr_d = clr_q + 17'd1;
    end else begin
      we    = req_i.wr && (host_i || !in_rom);
      addr  = req_i.addr;
      wdata = req_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  c6502_ram #(.Width(8), .Depth(c6502_pkg::MemDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .addr_i  (addr),
    .wdata_i (wdata),
    .rdata_o (rdata_o)
  );
endmodule

@@ rtl/cpu_6502_load_store_core.sv @@
// Top level of the 6502 load/store core: instruction sequencer and registers.
// Depends on c6502_pkg and c6502_mem.
//
// After reset the core clears its 64 KB memory, one byte a cycle, and busy
// stays high until the pass is done. A memory read passes through the request
// register and the registered read of the one-port RAM, so the sequencer
// holds after every read it issues until its data is back. The result of a
// host load is strobed after the StHost and StReport states, that of a CPU
// reset after two vector reads, and a run item that executes nothing goes
// straight to StReport. In a run item every opcode, operand, pointer and data
// read spends a tick of budget, and so does every write, but writes need no
// wait. The result appears on the output ports for one cycle with done_o high
// and cannot be held off; busy stays high during that cycle.
module cpu_6502_load_store_core #(
  parameter int PageBytes    = c6502_pkg::PageBytes,
  parameter int RomFirstPage = c6502_pkg::RomFirstPage,
  parameter int RomBytes     = c6502_pkg::RomBytes
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  mode_i,
  input  logic [15:0] host_address_i,
  input  logic [7:0]  host_data_i,
  input  logic [15:0] tick_budget_i,
  output logic        done_o,
  output logic [15:0] program_counter_o,
  output logic [7:0]  accumulator_o,
  output logic [7:0]  index_x_o,
  output logic [7:0]  index_y_o,
  output logic [7:0]  stack_pointer_o,
  output logic [7:0]  status_byte_o,
  output logic [15:0] instructions_done_o,
  output logic [2:0]  ticks_overrun_o,
  output logic        halted_illegal_o,
  output logic [7:0]  illegal_opcode_o
);
  typedef enum logic [3:0] {
    StIdle, StHost, StVecLo, StVecHi, StFetch, StDecode, StOp1, StOp2,
    StPtrHi, StData, StReport
  } state_e;

  typedef enum logic [2:0] {
    DstA, DstX, DstY, DstP, DstNone
  } dst_e;

  state_e      state_q;
  logic [15:0] pc_q, done_cnt_q;
  logic [7:0]  a_q, x_q, y_q, sp_q, p_q, op_q, bad_q, lo_q, ptr_q;
  logic        halt_q, host_q;
  logic [16:0] ticks_q;  // signed count of ticks left
  c6502_pkg::mem_req_t req_q;
  logic [7:0]  rdata;
  logic        clr_busy;

  c6502_mem #(
    .PageBytes(PageBytes), .RomFirstPage(RomFirstPage), .RomBytes(RomBytes)
  ) u_mem (
    .clk_i(clk_i), .rst_ni(rst_ni), .req_i(req_q), .host_i(host_q),
    .rdata_o(rdata), .clr_busy_o(clr_busy)
  );

  assign busy = (state_q != StIdle) || clr_busy || done_o;
  assign program_counter_o = pc_q;
  assign accumulator_o     = a_q;
  assign index_x_o         = x_q;
  assign index_y_o         = y_q;
  assign stack_pointer_o   = sp_q;
  assign status_byte_o     = p_q | 8'h20;
  assign instructions_done_o = done_cnt_q;
  assign ticks_overrun_o   = ticks_q[16] ? 3'(-ticks_q) : 3'd0;
  assign halted_illegal_o  = halt_q;
  assign illegal_opcode_o  = halt_q ? bad_q : 8'h00;

  function automatic logic [7:0] nzf(input logic [7:0] p, input logic [7:0] v);
    nzf = (p & 8'h7D) | (v & 8'h80) | ((v == 8'h00) ? 8'h02 : 8'h00);
  endfunction

  // Destination of a data read, and the store source.
  function automatic dst_e dst_of(input logic [7:0] op);
    case (op)
      c6502_pkg::OpLdaZp, c6502_pkg::OpLdaZpx, c6502_pkg::OpLdaAbs,
      c6502_pkg::OpLdaAbx, c6502_pkg::OpLdaAby, c6502_pkg::OpLdaIzx,
      c6502_pkg::OpLdaIzy, c6502_pkg::OpPla: dst_of = DstA;
      c6502_pkg::OpLdxZp, c6502_pkg::OpLdxZpy, c6502_pkg::OpLdxAbs,
      c6502_pkg::OpLdxAby: dst_of = DstX;
      c6502_pkg::OpLdyZp, c6502_pkg::OpLdyZpx, c6502_pkg::OpLdyAbs,
      c6502_pkg::OpLdyAbx: dst_of = DstY;
      c6502_pkg::OpPlp: dst_of = DstP;
      default: dst_of = DstNone;
    endcase
  endfunction

  function automatic logic [7:0] st_src(input logic [7:0] op, input logic [7:0] a,
                                        input logic [7:0] x, input logic [7:0] y);
    case (op)
      c6502_pkg::OpStxZp, c6502_pkg::OpStxZpy, c6502_pkg::OpStxAbs: st_src = x;
      c6502_pkg::OpStyZp, c6502_pkg::OpStyZpx, c6502_pkg::OpStyAbs: st_src = y;
      default: st_src = a;
    endcase
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pc_q <= '0; a_q <= '0; x_q <= '0; y_q <= '0; sp_q <= 8'hFF; p_q <= '0;
      halt_q <= 1'b0; bad_q <= '0; op_q <= '0; lo_q <= '0; ptr_q <= '0;
      done_cnt_q <= '0; ticks_q <= '0;
      host_q <= 1'b0; req_q <= '0; done_o <= 1'b0;
    end else begin
      req_q  <= '0;
      host_q <= 1'b0;
      done_o <= 1'b0;
      // A read is on the RAM port this cycle; its data is there next cycle.
      if (!req_q.rd) begin
        case (state_q)
          StIdle: begin
            if (start && !busy) begin
              done_cnt_q <= '0;
              ticks_q <= '0;
              case (mode_i)
                c6502_pkg::ModeLoad: begin
                  req_q  <= '{wr: 1'b1, rd: 1'b0, addr: host_address_i,
                              data: host_data_i};
                  host_q <= 1'b1;
                  state_q <= StHost;
                end
                c6502_pkg::ModeReset: begin
                  req_q <= '{wr: 1'b0, rd: 1'b1, addr: c6502_pkg::VecLo, data: 8'h00};
                  state_q <= StVecLo;
                end
                c6502_pkg::ModeRun: begin
                  if (halt_q || tick_budget_i == 16'd0) begin
                    state_q <= StReport;
                  end else begin
                    ticks_q <= {1'b0, tick_budget_i};
                    state_q <= StFetch;
                  end
                end
                default: state_q <= StReport;
              endcase
            end
          end
          StHost: state_q <= StReport;
          StVecLo: begin
            lo_q <= rdata;
            req_q <= '{wr: 1'b0, rd: 1'b1, addr: c6502_pkg::VecHi, data: 8'h00};
            state_q <= StVecHi;
          end
          StVecHi: begin
            pc_q <= {rdata, lo_q};
            sp_q <= 8'hFF; a_q <= '0; x_q <= '0; y_q <= '0; p_q <= '0;
            halt_q <= 1'b0; bad_q <= '0;
            state_q <= StReport;
          end
          StFetch: begin
            // Issue the opcode read unless the budget is spent; decode runs once the data is back.
            if (ticks_q[16] || ticks_q == 17'd0) begin
              state_q <= StReport;
            end else begin
              req_q <= '{wr: 1'b0, rd: 1'b1, addr: pc_q, data: 8'h00};
              pc_q <= pc_q + 16'd1;
              ticks_q <= ticks_q - 17'd1;
              state_q <= StDecode;
            end
          end
          StDecode: begin
            op_q <= rdata;
            state_q <= StFetch;
            case (rdata)
              c6502_pkg::OpTax: begin x_q <= a_q; p_q <= nzf(p_q, a_q); end
              c6502_pkg::OpTay: begin y_q <= a_q; p_q <= nzf(p_q, a_q); end
              c6502_pkg::OpTxa: begin a_q <= x_q; p_q <= nzf(p_q, x_q); end
              c6502_pkg::OpTya: begin a_q <= y_q; p_q <= nzf(p_q, y_q); end
              c6502_pkg::OpTsx: begin x_q <= sp_q; p_q <= nzf(p_q, sp_q); end
              c6502_pkg::OpTxs: sp_q <= x_q;
              c6502_pkg::OpPha, c6502_pkg::OpPhp: begin
                req_q <= '{wr: 1'b1, rd: 1'b0, addr: {8'h01, sp_q},
                           data: (rdata == c6502_pkg::OpPha) ? a_q : (p_q | 8'h20)};
                sp_q <= sp_q - 8'd1;
                ticks_q <= ticks_q - 17'd1;
              end
              c6502_pkg::OpPla, c6502_pkg::OpPlp: begin
                req_q <= '{wr: 1'b0, rd: 1'b1, addr: {8'h01, sp_q + 8'd1}, data: 8'h00};
                sp_q <= sp_q + 8'd1;
                ticks_q <= ticks_q - 17'd1;
                state_q <= StData;
              end
              c6502_pkg::OpLdaImm, c6502_pkg::OpLdxImm, c6502_pkg::OpLdyImm,
              c6502_pkg::OpLdaZp, c6502_pkg::OpLdaZpx, c6502_pkg::OpLdaAbs,
              c6502_pkg::OpLdaAbx, c6502_pkg::OpLdaAby, c6502_pkg::OpLdaIzx,
              c6502_pkg::OpLdaIzy, c6502_pkg::OpLdxZp, c6502_pkg::OpLdxZpy,
              c6502_pkg::OpLdxAbs, c6502_pkg::OpLdxAby, c6502_pkg::OpLdyZp,
              c6502_pkg::OpLdyZpx, c6502_pkg::OpLdyAbs, c6502_pkg::OpLdyAbx,
              c6502_pkg::OpStaZp, c6502_pkg::OpStaZpx, c6502_pkg::OpStaAbs,
              c6502_pkg::OpStaAbx, c6502_pkg::OpStaAby, c6502_pkg::OpStxZp,
              c6502_pkg::OpStxZpy, c6502_pkg::OpStxAbs, c6502_pkg::OpStyZp,
              c6502_pkg::OpStyZpx, c6502_pkg::OpStyAbs, c6502_pkg::OpJmp: begin
                req_q <= '{wr: 1'b0, rd: 1'b1, addr: pc_q, data: 8'h00};
                pc_q <= pc_q + 16'd1;
                ticks_q <= ticks_q - 17'd1;
                state_q <= StOp1;
              end
              default: begin
                halt_q <= 1'b1;
                bad_q <= rdata;
                state_q <= StReport;
              end
            endcase
            if (dst_of(rdata) == DstNone && rdata != c6502_pkg::OpPha &&
                rdata != c6502_pkg::OpPhp &&
                (rdata == c6502_pkg::OpTax || rdata == c6502_pkg::OpTay ||
                 rdata == c6502_pkg::OpTxa || rdata == c6502_pkg::OpTya ||
                 rdata == c6502_pkg::OpTsx || rdata == c6502_pkg::OpTxs)) begin
              done_cnt_q <= done_cnt_q + 16'd1;
            end
            if (rdata == c6502_pkg::OpPha || rdata == c6502_pkg::OpPhp) begin
              done_cnt_q <= done_cnt_q + 16'd1;
            end
          end
          StOp1: begin
            // First operand byte is in rdata.
            lo_q <= rdata;
            state_q <= StFetch;
            case (op_q)
              c6502_pkg::OpLdaImm: begin a_q <= rdata; p_q <= nzf(p_q, rdata);
                done_cnt_q <= done_cnt_q + 16'd1; end
              c6502_pkg::OpLdxImm: begin x_q <= rdata; p_q <= nzf(p_q, rdata);
                done_cnt_q <= done_cnt_q + 16'd1; end
              c6502_pkg::OpLdyImm: begin y_q <= rdata; p_q <= nzf(p_q, rdata);
                done_cnt_q <= done_cnt_q + 16'd1; end
              c6502_pkg::OpLdaZp, c6502_pkg::OpLdxZp, c6502_pkg::OpLdyZp: begin
                req_q <= '{wr: 1'b0, rd: 1'b1, addr: {8'h00, rdata}, data: 8'h00};
                ticks_q <= ticks_q - 17'd1;
                state_q <= StData;
              end
              c6502_pkg::OpLdaZpx, c6502_pkg::OpLdyZpx: begin
                req_q <= '{wr: 1'b0, rd: 1'b1, addr: {8'h00, rdata + x_q}, data: 8'h00};
                ticks_q <= ticks_q - 17'd1;
                state_q <= StData;
              end
              c6502_pkg::OpLdxZpy: begin
                req_q <= '{wr: 1'b0, rd: 1'b1, addr: {8'h00, rdata + y_q}, data: 8'h00};
                ticks_q <= ticks_q - 17'd1;
                state_q <= StData;
              end
              c6502_pkg::OpStaZp, c6502_pkg::OpStxZp, c6502_pkg::OpStyZp,
              c6502_pkg::OpStaZpx, c6502_pkg::OpStyZpx, c6502_pkg::OpStxZpy: begin
                req_q <= '{wr: 1'b1, rd: 1'b0,
                           addr: {8'h00, rdata + ((op_q == c6502_pkg::OpStxZpy) ? y_q :
                                 (op_q == c6502_pkg::OpStaZpx ||
                                  op_q == c6502_pkg::OpStyZpx) ? x_q : 8'h00)},
                           data: st_src(op_q, a_q, x_q, y_q)};
                ticks_q <= ticks_q - 17'd1;
                done_cnt_q <= done_cnt_q + 16'd1;
              end
              c6502_pkg::OpLdaIzx: begin
                ptr_q <= rdata + x_q;
                req_q <= '{wr: 1'b0, rd: 1'b1, addr: {8'h00, rdata + x_q}, data: 8'h00};
                ticks_q <= ticks_q - 17'd1;
                state_q <= StOp2;
              end
              c6502_pkg::OpLdaIzy: begin
                ptr_q <= rdata;
                req_q <= '{wr: 1'b0, rd: 1'b1, addr: {8'h00, rdata}, data: 8'h00};
                ticks_q <= ticks_q - 17'd1;
                state_q <= StOp2;
              end
              default: begin
                // Absolute modes: fetch the high operand byte.
                req_q <= '{wr: 1'b0, rd: 1'b1, addr: pc_q, data: 8'h00};
                pc_q <= pc_q + 16'd1;
                ticks_q <= ticks_q - 17'd1;
                state_q <= StOp2;
              end
            endcase
          end
          StOp2: begin
            state_q <= StFetch;
            case (op_q)
              c6502_pkg::OpLdaIzx, c6502_pkg::OpLdaIzy: begin
                lo_q <= rdata;
                req_q <= '{wr: 1'b0, rd: 1'b1, addr: {8'h00, ptr_q + 8'd1}, data: 8'h00};
                ticks_q <= ticks_q - 17'd1;
                state_q <= StPtrHi;
              end
              c6502_pkg::OpJmp: begin
                pc_q <= {rdata, lo_q};
                done_cnt_q <= done_cnt_q + 16'd1;
              end
              c6502_pkg::OpLdaAbs, c6502_pkg::OpLdxAbs, c6502_pkg::OpLdyAbs,
              c6502_pkg::OpLdaAbx, c6502_pkg::OpLdyAbx, c6502_pkg::OpLdaAby,
              c6502_pkg::OpLdxAby: begin
                req_q <= '{wr: 1'b0, rd: 1'b1,
                           addr: {rdata, lo_q} + {8'h00,
                                 (op_q == c6502_pkg::OpLdaAbx || op_q == c6502_pkg::OpLdyAbx)
                                 ? x_q : (op_q == c6502_pkg::OpLdaAby ||
                                          op_q == c6502_pkg::OpLdxAby) ? y_q : 8'h00},
                           data: 8'h00};
                ticks_q <= ticks_q - 17'd1;
                state_q <= StData;
              end
              default: begin
                // Absolute stores.
                req_q <= '{wr: 1'b1, rd: 1'b0,
                           addr: {rdata, lo_q} + {8'h00,
                                 (op_q == c6502_pkg::OpStaAbx) ? x_q :
                                 (op_q == c6502_pkg::OpStaAby) ? y_q : 8'h00},
                           data: st_src(op_q, a_q, x_q, y_q)};
                ticks_q <= ticks_q - 17'd1;
                done_cnt_q <= done_cnt_q + 16'd1;
              end
            endcase
          end
          StPtrHi: begin
            req_q <= '{wr: 1'b0, rd: 1'b1,
                       addr: {rdata, lo_q} + {8'h00,
                             (op_q == c6502_pkg::OpLdaIzy) ? y_q : 8'h00},
                       data: 8'h00};
            ticks_q <= ticks_q - 17'd1;
            state_q <= StData;
          end
          StData: begin
            done_cnt_q <= done_cnt_q + 16'd1;
            state_q <= StFetch;
            case (dst_of(op_q))
              DstA: begin a_q <= rdata; p_q <= nzf(p_q, rdata); end
              DstX: begin x_q <= rdata; p_q <= nzf(p_q, rdata); end
              DstY: begin y_q <= rdata; p_q <= nzf(p_q, rdata); end
              DstP: p_q <= rdata & 8'hDF;
              default: ;
            endcase
          end
          StReport: begin
            done_o <= 1'b1;
            state_q <= StIdle;
          end
          default: state_q <= StIdle;
        endcase
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q) == StReport)
    else $error("result strobe without report state");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_q.wr && clr_busy) |-> 1'b0)
    else $error("write requested during clearing pass");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFetch && !ticks_q[16] && ticks_q != 17'd0) |=> state_q == StDecode)
    else $error("opcode fetch did not lead to decode");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_q.wr && req_q.rd))
    else $error("read and write requested together");
endmodule

@@ bench/tb_cpu_6502_load_store_core.sv @@
// Self-checking bench for cpu_6502_load_store_core: directed corner cases, then random programs.
// Depends on c6502_pkg and the core RTL; a scoreboard class predicts each result word.
`timescale 1ns / 100ps

module tb_cpu_6502_load_store_core;

  // Mode code that the core does not use; it must leave the state alone.
  localparam logic [1:0] ModeSpare = 2'd3;

  typedef struct packed {
    logic [15:0] pc;
    logic [7:0]  a;
    logic [7:0]  x;
    logic [7:0]  y;
    logic [7:0]  sp;
    logic [7:0]  status;
    logic [15:0] done_cnt;
    logic [2:0]  overrun;
    logic        halted;
    logic [7:0]  bad_op;
  } cpu_word_t;

  class cpu_scoreboard;
    logic [7:0]  mem [c6502_pkg::MemDepth];
    logic [15:0] pc;
    logic [7:0]  a, x, y, sp, flags, bad_op;
    logic        halted;
    int          ticks;
    int          errors;
    cpu_word_t   pending[$];

    function new();
      foreach (mem[i]) mem[i] = 8'h00;
      pc = 16'h0000; a = 8'h00; x = 8'h00; y = 8'h00; sp = 8'hFF; flags = 8'h00;
      halted = 1'b0; bad_op = 8'h00; errors = 0; ticks = 0;
    endfunction

    function logic [7:0] rd(int addr);
      ticks--;
      return mem[addr & 16'hFFFF];
    endfunction

    function void wr(int addr, logic [7:0] v);
      addr &= 16'hFFFF;
      ticks--;
      // CPU stores into the ROM window are dropped.
      if (addr < c6502_pkg::RomFirstPage * c6502_pkg::PageBytes ||
          addr >= c6502_pkg::RomFirstPage * c6502_pkg::PageBytes + c6502_pkg::RomBytes)
        mem[addr] = v;
    endfunction

    function logic [7:0] fetch();
      logic [7:0] v;
      v = rd(pc);
      pc = pc + 16'd1;
      return v;
    endfunction

    function int fetch_abs();
      int lo;
      lo = fetch();
      return lo | (int'(fetch()) << 8);
    endfunction

    function logic [7:0] nz(logic [7:0] v);
      flags = flags & 8'h7D;
      if (v == 8'h00) flags |= 8'h02;
      flags |= v & 8'h80;
      return v;
    endfunction

    function bit step_instr();
      logic [7:0] op;
      int ea, ptr;
      op = fetch();
      case (op)
        c6502_pkg::OpLdaImm: a = nz(fetch());
        c6502_pkg::OpLdaZp:  a = nz(rd(fetch()));
        c6502_pkg::OpLdaZpx: a = nz(rd((fetch() + x) & 8'hFF));
        c6502_pkg::OpLdaAbs: a = nz(rd(fetch_abs()));
        c6502_pkg::OpLdaAbx: a = nz(rd(fetch_abs() + x));
        c6502_pkg::OpLdaAby: a = nz(rd(fetch_abs() + y));
        c6502_pkg::OpLdaIzx: begin
          ptr = fetch() + x;
          ea = rd(ptr & 8'hFF);
          ea |= int'(rd((ptr + 1) & 8'hFF)) << 8;
          a = nz(rd(ea));
        end
        c6502_pkg::OpLdaIzy: begin
          ptr = fetch();
          ea = rd(ptr);
          ea |= int'(rd((ptr + 1) & 8'hFF)) << 8;
          a = nz(rd(ea + y));
        end
        c6502_pkg::OpLdxImm: x = nz(fetch());
        c6502_pkg::OpLdxZp:  x = nz(rd(fetch()));
        c6502_pkg::OpLdxZpy: x = nz(rd((fetch() + y) & 8'hFF));
        c6502_pkg::OpLdxAbs: x = nz(rd(fetch_abs()));
        c6502_pkg::OpLdxAby: x = nz(rd(fetch_abs() + y));
        c6502_pkg::OpLdyImm: y = nz(fetch());
        c6502_pkg::OpLdyZp:  y = nz(rd(fetch()));
        c6502_pkg::OpLdyZpx: y = nz(rd((fetch() + x) & 8'hFF));
        c6502_pkg::OpLdyAbs: y = nz(rd(fetch_abs()));
        c6502_pkg::OpLdyAbx: y = nz(rd(fetch_abs() + x));
        c6502_pkg::OpStaZp:  wr(fetch(), a);
        c6502_pkg::OpStaZpx: wr((fetch() + x) & 8'hFF, a);
        c6502_pkg::OpStaAbs: wr(fetch_abs(), a);
        c6502_pkg::OpStaAbx: wr(fetch_abs() + x, a);
        c6502_pkg::OpStaAby: wr(fetch_abs() + y, a);
        c6502_pkg::OpStxZp:  wr(fetch(), x);
        c6502_pkg::OpStxZpy: wr((fetch() + y) & 8'hFF, x);
        c6502_pkg::OpStxAbs: wr(fetch_abs(), x);
        c6502_pkg::OpStyZp:  wr(fetch(), y);
        c6502_pkg::OpStyZpx: wr((fetch() + x) & 8'hFF, y);
        c6502_pkg::OpStyAbs: wr(fetch_abs(), y);
        c6502_pkg::OpTax: x = nz(a);
        c6502_pkg::OpTay: y = nz(a);
        c6502_pkg::OpTxa: a = nz(x);
        c6502_pkg::OpTya: a = nz(y);
        c6502_pkg::OpTsx: x = nz(sp);
        c6502_pkg::OpTxs: sp = x;
        c6502_pkg::OpPha: begin wr(16'h100 + sp, a); sp = sp - 8'd1; end
        c6502_pkg::OpPhp: begin wr(16'h100 + sp, flags | 8'h20); sp = sp - 8'd1; end
        c6502_pkg::OpPla: begin sp = sp + 8'd1; a = nz(rd(16'h100 + sp)); end
        c6502_pkg::OpPlp: begin sp = sp + 8'd1; flags = rd(16'h100 + sp) & 8'hDF; end
        c6502_pkg::OpJmp: pc = 16'(fetch_abs());
        default: begin
          halted = 1'b1; bad_op = op;
          return 1'b0;
        end
      endcase
      return 1'b1;
    endfunction

    // Applies one accepted command word and queues the result it must produce.
    function void note_command(logic [1:0] mode, logic [15:0] addr, logic [7:0] data,
                               logic [15:0] budget);
      cpu_word_t w;
      int done_cnt;
      done_cnt = 0;
      ticks = 0;
      if (mode == c6502_pkg::ModeLoad) begin
        mem[addr] = data;
      end else if (mode == c6502_pkg::ModeReset) begin
        pc = {mem[c6502_pkg::VecHi], mem[c6502_pkg::VecLo]};
        sp = 8'hFF; a = 8'h00; x = 8'h00; y = 8'h00; flags = 8'h00;
        halted = 1'b0; bad_op = 8'h00;
      end else if (mode == c6502_pkg::ModeRun && !halted) begin
        ticks = budget;
        while (ticks > 0) begin
          if (!step_instr()) break;
          done_cnt++;
        end
      end
      w.pc = pc; w.a = a; w.x = x; w.y = y; w.sp = sp; w.status = flags | 8'h20;
      w.done_cnt = 16'(done_cnt);
      w.overrun = (ticks < 0) ? 3'(-ticks) : 3'd0;
      w.halted = halted;
      w.bad_op = halted ? bad_op : 8'h00;
      pending.push_back(w);
    endfunction

    function void check_result(cpu_word_t got);
      cpu_word_t exp;
      if (pending.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
        return;
      end
      exp = pending.pop_front();
      if (got.pc != exp.pc) begin
        $error("program_counter exp %h got %h", exp.pc, got.pc); errors++;
      end
      if (got.a != exp.a) begin
        $error("accumulator exp %h got %h", exp.a, got.a); errors++;
      end
      if (got.x != exp.x) begin
        $error("index_x exp %h got %h", exp.x, got.x); errors++;
      end
      if (got.y != exp.y) begin
        $error("index_y exp %h got %h", exp.y, got.y); errors++;
      end
      if (got.sp != exp.sp) begin
        $error("stack_pointer exp %h got %h", exp.sp, got.sp); errors++;
      end
      if (got.status != exp.status) begin
        $error("status_byte exp %h got %h", exp.status, got.status); errors++;
      end
      if (got.done_cnt != exp.done_cnt) begin
        $error("instructions_done exp %0d got %0d", exp.done_cnt, got.done_cnt); errors++;
      end
      if (got.overrun != exp.overrun) begin
        $error("ticks_overrun exp %0d got %0d", exp.overrun, got.overrun); errors++;
      end
      if (got.halted != exp.halted) begin
        $error("halted_illegal exp %b got %b", exp.halted, got.halted); errors++;
      end
      if (got.bad_op != exp.bad_op) begin
        $error("illegal_opcode exp %h got %h", exp.bad_op, got.bad_op); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  mode_i = 0;
  logic [15:0] host_address_i = 0;
  logic [7:0]  host_data_i = 0;
  logic [15:0] tick_budget_i = 0;
  logic        done_o;
  logic [15:0] res_pc, res_done_cnt;
  logic [7:0]  res_a, res_x, res_y, res_sp, res_status, res_bad_op;
  logic [2:0]  res_overrun;
  logic        res_halted;
  cpu_word_t   res;

  cpu_6502_load_store_core dut (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .host_address_i, .host_data_i, .tick_budget_i,
    .done_o,
    .program_counter_o(res_pc), .accumulator_o(res_a), .index_x_o(res_x),
    .index_y_o(res_y), .stack_pointer_o(res_sp), .status_byte_o(res_status),
    .instructions_done_o(res_done_cnt), .ticks_overrun_o(res_overrun),
    .halted_illegal_o(res_halted), .illegal_opcode_o(res_bad_op)
  );

  assign res = {res_pc, res_a, res_x, res_y, res_sp, res_status, res_done_cnt,
                res_overrun, res_halted, res_bad_op};

  always #4 clk_i = ~clk_i;

  cpu_scoreboard sb = new();
  int            words_sent = 0;
  logic [7:0]    legal_ops[$];

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_result(res);
  end

  initial begin
    #(64'd200_000_000);
    $display("TEST FAILED");
    $finish;
  end

  task automatic send_word(logic [1:0] mode, logic [15:0] addr, logic [7:0] data,
                           logic [15:0] budget);
    int gap, idle_pct;
    idle_pct = (words_sent < 600) ? 37 : (words_sent < 1200) ? 56 : 0;
    gap = ($urandom_range(0, 99) < idle_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    mode_i <= mode;
    host_address_i <= addr;
    host_data_i <= data;
    tick_budget_i <= budget;
    do @(posedge clk_i); while (busy);
    sb.note_command(mode, addr, data, budget);
    words_sent++;
  endtask

  task automatic host_load(logic [15:0] addr, logic [7:0] data);
    send_word(c6502_pkg::ModeLoad, addr, data, 16'($urandom()));
  endtask

  task automatic run(logic [15:0] budget);
    send_word(c6502_pkg::ModeRun, 16'($urandom()), 8'($urandom()), budget);
  endtask

  function automatic int op_length(logic [7:0] op);
    case (op)
      c6502_pkg::OpLdaAbs, c6502_pkg::OpLdaAbx, c6502_pkg::OpLdaAby, c6502_pkg::OpLdxAbs,
      c6502_pkg::OpLdxAby, c6502_pkg::OpLdyAbs, c6502_pkg::OpLdyAbx, c6502_pkg::OpStaAbs,
      c6502_pkg::OpStaAbx, c6502_pkg::OpStaAby, c6502_pkg::OpStxAbs, c6502_pkg::OpStyAbs,
      c6502_pkg::OpJmp: return 3;
      c6502_pkg::OpTax, c6502_pkg::OpTay, c6502_pkg::OpTxa, c6502_pkg::OpTya,
      c6502_pkg::OpTsx, c6502_pkg::OpTxs, c6502_pkg::OpPha, c6502_pkg::OpPhp,
      c6502_pkg::OpPla, c6502_pkg::OpPlp: return 1;
      default: return 2;
    endcase
  endfunction

  function automatic logic [7:0] pick_opcode();
    logic [7:0] op;
    if ($urandom_range(0, 29) != 0) return legal_ops[$urandom_range(0, legal_ops.size() - 1)];
    // Pick a byte outside the supported set.
    do op = 8'($urandom()); while (op inside {legal_ops});
    return op;
  endfunction

  // Sends up to five stray words, writes a random program at base, points the reset vector at it, resets and runs it.
  task automatic program_episode();
    logic [15:0] base, addr, jmp_to;
    logic [7:0]  op;
    int n, len;
    base = 16'($urandom());
    addr = base;
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 3))
        0: host_load(16'($urandom_range(0, 255)), 8'($urandom()));
        1: host_load(16'(16'h100 + $urandom_range(0, 255)), 8'($urandom()));
        2: host_load(16'($urandom()), 8'($urandom()));
        default: send_word(ModeSpare, 16'($urandom()), 8'($urandom()), 16'($urandom()));
      endcase
    end
    n = $urandom_range(3, 12);
    repeat (n) begin
      op = pick_opcode();
      len = op_length(op);
      host_load(addr, op);
      if (op == c6502_pkg::OpJmp) begin
        jmp_to = ($urandom_range(0, 1) == 0) ? base : 16'($urandom());
        host_load(addr + 16'd1, jmp_to[7:0]);
        host_load(addr + 16'd2, jmp_to[15:8]);
      end else begin
        for (int i = 1; i < len; i++) host_load(16'(addr + i), 8'($urandom()));
      end
      addr = 16'(addr + len);
    end
    host_load(c6502_pkg::VecLo, base[7:0]);
    host_load(c6502_pkg::VecHi, base[15:8]);
    send_word(c6502_pkg::ModeReset, 16'($urandom()), 8'($urandom()), 16'($urandom()));
    repeat ($urandom_range(1, 4)) begin
      run(($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 400))
                                      : 16'($urandom_range(0, 24)));
    end
  endtask

  initial begin
    legal_ops = '{c6502_pkg::OpLdaImm, c6502_pkg::OpLdaZp, c6502_pkg::OpLdaZpx,
                  c6502_pkg::OpLdaAbs, c6502_pkg::OpLdaAbx, c6502_pkg::OpLdaAby,
                  c6502_pkg::OpLdaIzx, c6502_pkg::OpLdaIzy, c6502_pkg::OpLdxImm,
                  c6502_pkg::OpLdxZp, c6502_pkg::OpLdxZpy, c6502_pkg::OpLdxAbs,
                  c6502_pkg::OpLdxAby, c6502_pkg::OpLdyImm, c6502_pkg::OpLdyZp,
                  c6502_pkg::OpLdyZpx, c6502_pkg::OpLdyAbs, c6502_pkg::OpLdyAbx,
                  c6502_pkg::OpStaZp, c6502_pkg::OpStaZpx, c6502_pkg::OpStaAbs,
                  c6502_pkg::OpStaAbx, c6502_pkg::OpStaAby, c6502_pkg::OpStxZp,
                  c6502_pkg::OpStxZpy, c6502_pkg::OpStxAbs, c6502_pkg::OpStyZp,
                  c6502_pkg::OpStyZpx, c6502_pkg::OpStyAbs, c6502_pkg::OpTax,
                  c6502_pkg::OpTay, c6502_pkg::OpTxa, c6502_pkg::OpTya, c6502_pkg::OpTsx,
                  c6502_pkg::OpTxs, c6502_pkg::OpPha, c6502_pkg::OpPhp, c6502_pkg::OpPla,
                  c6502_pkg::OpPlp, c6502_pkg::OpJmp};
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a jump-to-self loop eats the full budget.
    send_word(c6502_pkg::ModeRun, 16'h0000, 8'h00, 16'h0000);
    host_load(c6502_pkg::VecLo, 8'h00);
    host_load(c6502_pkg::VecHi, 8'h03);
    host_load(16'h0300, c6502_pkg::OpJmp);
    host_load(16'h0301, 8'h00);
    host_load(16'h0302, 8'h03);
    send_word(c6502_pkg::ModeReset, 16'hFFFF, 8'hFF, 16'hFFFF);
    run(16'hFFFF);
    send_word(ModeSpare, 16'hFFFF, 8'hFF, 16'hFFFF);
    run(16'h0000);
    host_load(16'h0300, 8'hFF);
    host_load(16'hFFFF, 8'hFF);
    host_load(16'h0000, 8'h00);
    run(16'h0001);
    run(16'h8000);
    send_word(c6502_pkg::ModeReset, 16'h0000, 8'h00, 16'h0000);

    while (words_sent < 1800) begin
      program_episode();
      if (words_sent > 900 && words_sent < 960) begin
        // Hold the sender off until the core has drained every word.
        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge clk_i);
      end
    end
    start <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
